>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file fmsc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the cycle after.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fmsc_pkg.sv
package fmsc_pkg;

    localparam int SPEED_W    = 13;
    localparam int FULL_SCALE = 4096;
    localparam int POT_Q_W    = 12;
    localparam int TEMP_W     = 12;
    localparam int DIST_W     = 16;
    localparam int STEP_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Link packet characters.
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_PRESS   = 8'h31;
    localparam logic [7:0] BTN_MOTION = 8'h31;
    localparam logic [7:0] BTN_TEMP   = 8'h32;
    localparam logic [7:0] BTN_MANUAL = 8'h33;
    localparam logic [7:0] BTN_UP     = 8'h35;
    localparam logic [7:0] BTN_DOWN   = 8'h36;
    localparam logic [7:0] BTN_ZERO   = 8'h37;

    typedef enum logic {
        OP_LINK_BYTE = 1'b0,
        OP_TICK      = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_MOTION = 2'd0,
        MODE_TEMP   = 2'd1,
        MODE_MANUAL = 2'd2
    } t_fan_mode;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BANG   = 3'd1,
        PH_CODE   = 3'd2,
        PH_ACTION = 3'd3,
        PH_SUM    = 3'd4
    } t_parse_phase;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_MOTION,
        CMD_TEMP,
        CMD_MANUAL,
        CMD_UP,
        CMD_DOWN,
        CMD_ZERO
    } t_cmd_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_STEP   = 2'd0,
        CFG_NEAR_LIMIT_MM = 2'd1,
        CFG_HOT_THRESHOLD = 2'd2
    } t_cfg_index;

    localparam logic [STEP_W-1:0] RST_OFFSET_STEP   = 13'd410;
    localparam logic [DIST_W-1:0] RST_NEAR_LIMIT_MM = 16'd500;
    localparam logic [TEMP_W-1:0] RST_HOT_THRESHOLD = 12'd917;

endpackage

>>> hdl/fmsc_intf.sv
interface fmsc_req_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [7:0]             rx_byte;
    logic [SAMPLE_BITS-1:0] pot_level;
    logic [11:0]            temp_level;
    logic [15:0]            distance_mm;
    logic                   distance_ok;
    logic                   button_one_n;
    logic                   button_two_n;
    logic                   button_three_n;

    modport source (
        output valid, opcode, rx_byte, pot_level, temp_level, distance_mm,
               distance_ok, button_one_n, button_two_n, button_three_n,
        input  ready
    );
    modport sink (
        input  valid, opcode, rx_byte, pot_level, temp_level, distance_mm,
               distance_ok, button_one_n, button_two_n, button_three_n,
        output ready
    );
endinterface

interface fmsc_rsp_if #(
    parameter int OFFSET_W = 15
) ();
    logic                       valid;
    logic                       ready;
    logic [12:0]                motor_speed;
    logic [1:0]                 fan_mode;
    logic signed [OFFSET_W-1:0] offset_value;

    modport source (
        output valid, motor_speed, fan_mode, offset_value,
        input  ready
    );
    modport sink (
        input  valid, motor_speed, fan_mode, offset_value,
        output ready
    );
endinterface

>>> hdl/fmsc_parser.sv
module fmsc_parser
    import fmsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_byte,
    output t_cmd_kind  o_cmd
);

    t_parse_phase r_phase;
    t_parse_phase n_phase;
    logic [7:0]   r_code;
    logic [7:0]   r_action;
    logic [7:0]   w_sum;

    // The checksum byte is the complement of the low byte of the packet sum.
    assign w_sum = CH_BANG + CH_B + r_code + r_action;

    always_comb begin
        n_phase = r_phase;
        if (i_byte_valid) begin
            unique case (r_phase)
                PH_BANG:   n_phase = (i_byte == CH_B) ? PH_CODE : PH_IDLE;
                PH_CODE:   n_phase = PH_ACTION;
                PH_ACTION: n_phase = PH_SUM;
                PH_SUM:    n_phase = PH_IDLE;
                default:   n_phase = (i_byte == CH_BANG) ? PH_BANG : PH_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = CMD_NONE;
        if (i_byte_valid && r_phase == PH_SUM && i_byte == ~w_sum
                && r_action == CH_PRESS) begin
            case (r_code)
                BTN_MOTION: o_cmd = CMD_MOTION;
                BTN_TEMP:   o_cmd = CMD_TEMP;
                BTN_MANUAL: o_cmd = CMD_MANUAL;
                BTN_UP:     o_cmd = CMD_UP;
                BTN_DOWN:   o_cmd = CMD_DOWN;
                BTN_ZERO:   o_cmd = CMD_ZERO;
                default:    o_cmd = CMD_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_code   <= 8'd0;
            r_action <= 8'd0;
        end else begin
            r_phase <= n_phase;
            if (i_byte_valid && r_phase == PH_CODE) begin
                r_code <= i_byte;
            end
            if (i_byte_valid && r_phase == PH_ACTION) begin
                r_action <= i_byte;
            end
        end
    end

endmodule

>>> hdl/fan_mode_speed_controller_unit.sv
// Channel  | Dir | Handshake    | Payload
// i_req    | in  | valid/ready  | opcode, rx_byte, pot_level, temp_level, distance_mm,
//          |     |              | distance_ok, button_one_n/two_n/three_n
// o_rsp    | out | valid/ready  | motor_speed, fan_mode, offset_value (tick requests only)
// i_cfg_*  | in  | write enable | register index, write data
//
// One request is taken per cycle unless a tick request waits on a held result; a tick result
// passes through the input register, then the result register.
// Reset is synchronous and restores control registers at once, with no clearing pass.
// Data registers are not reset. A held result blocks a tick and all requests after it.

module fan_mode_speed_controller_unit
    import fmsc_pkg::*;
#(
    parameter int SAMPLE_BITS  = 12,
    parameter int OFFSET_LIMIT = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fmsc_req_if.sink              i_req,
    fmsc_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OFFSET_W = $clog2(OFFSET_LIMIT) + 2;
    localparam int WIDE_W   = OFFSET_W + 3;

    localparam logic signed [WIDE_W-1:0] LIMIT_WIDE = WIDE_W'(OFFSET_LIMIT);
    localparam logic signed [WIDE_W-1:0] FULL_WIDE  = WIDE_W'(FULL_SCALE);

    function automatic logic signed [OFFSET_W-1:0] sat_offset(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > LIMIT_WIDE) begin
            r = LIMIT_WIDE;
        end else if (v < -LIMIT_WIDE) begin
            r = -LIMIT_WIDE;
        end
        return r[OFFSET_W-1:0];
    endfunction

    // Configuration registers
    logic [STEP_W-1:0] r_offset_step;
    logic [DIST_W-1:0] r_near_limit;
    logic [TEMP_W-1:0] r_hot_thr;

    // Input register
    logic                   r_in_valid;
    t_opcode                r_in_op;
    logic [7:0]             r_in_byte;
    logic [SAMPLE_BITS-1:0] r_in_pot;
    logic [TEMP_W-1:0]      r_in_temp;
    logic [DIST_W-1:0]      r_in_dist;
    logic                   r_in_dist_ok;
    logic                   r_in_b1_n;
    logic                   r_in_b2_n;
    logic                   r_in_b3_n;

    // Controller state
    t_fan_mode                  r_mode;
    t_fan_mode                  n_mode;
    logic signed [OFFSET_W-1:0] r_offset;
    logic signed [OFFSET_W-1:0] n_offset;
    logic [SPEED_W-1:0]         r_held;
    logic [SPEED_W-1:0]         n_held;
    logic                       r_hot;
    logic                       n_hot;

    // Result register
    logic                       r_out_valid;
    logic [SPEED_W-1:0]         r_out_speed;
    t_fan_mode                  r_out_mode;
    logic signed [OFFSET_W-1:0] r_out_offset;

    logic                       w_advance;
    logic                       w_tick;
    logic                       w_byte_valid;
    t_cmd_kind                  w_cmd;
    t_fan_mode                  w_tick_mode;
    logic [POT_Q_W-1:0]         w_pot;
    logic signed [WIDE_W-1:0]   w_pot_wide;
    logic signed [WIDE_W-1:0]   w_off_wide;
    logic signed [WIDE_W-1:0]   w_step_wide;
    logic signed [WIDE_W-1:0]   w_sum;
    logic [SPEED_W-1:0]         w_run_speed;
    logic signed [OFFSET_W-1:0] w_run_offset;
    logic [SPEED_W-1:0]         w_speed;

    assign w_tick       = r_in_valid && r_in_op == OP_TICK;
    assign w_advance    = r_in_valid && (r_in_op == OP_LINK_BYTE || !r_out_valid || o_rsp.ready);
    assign w_byte_valid = w_advance && r_in_op == OP_LINK_BYTE;
    assign i_req.ready  = !r_in_valid || w_advance;

    fmsc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_byte_valid),
        .i_byte       (r_in_byte),
        .o_cmd        (w_cmd)
    );

    // Scale the potentiometer sample to Q0.12.
    generate
        if (SAMPLE_BITS >= POT_Q_W) begin : g_pot_down
            assign w_pot = r_in_pot[SAMPLE_BITS-1 -: POT_Q_W];
        end else begin : g_pot_up
            assign w_pot = {r_in_pot, {(POT_Q_W - SAMPLE_BITS){1'b0}}};
        end
    endgenerate

    assign w_pot_wide  = $signed({{(WIDE_W - POT_Q_W){1'b0}}, w_pot});
    assign w_off_wide  = {{(WIDE_W - OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset};
    assign w_step_wide = $signed({{(WIDE_W - STEP_W){1'b0}}, r_offset_step});
    assign w_sum       = w_pot_wide + w_off_wide;

    // Clamp the drive level; overshooting full scale backs the offset off by one step,
    // and undershooting zero pins the offset so that pot plus offset is exactly zero.
    always_comb begin
        w_run_offset = r_offset;
        w_run_speed  = w_sum[SPEED_W-1:0];
        if (w_sum > FULL_WIDE) begin
            w_run_speed  = SPEED_W'(FULL_SCALE);
            w_run_offset = sat_offset(w_off_wide - w_step_wide);
        end else if (w_sum < 0) begin
            w_run_speed  = '0;
            w_run_offset = OFFSET_W'(-w_pot_wide);
        end
    end

    always_comb begin
        if (!r_in_b1_n) begin
            w_tick_mode = MODE_MOTION;
        end else if (!r_in_b2_n) begin
            w_tick_mode = MODE_TEMP;
        end else if (!r_in_b3_n) begin
            w_tick_mode = MODE_MANUAL;
        end else begin
            w_tick_mode = r_mode;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_offset = r_offset;
        n_held   = r_held;
        n_hot    = r_hot;
        w_speed  = '0;
        if (w_advance && w_tick) begin
            n_mode = w_tick_mode;
            case (w_tick_mode)
                MODE_MOTION: begin
                    if (!r_in_dist_ok) begin
                        w_speed = r_held;
                    end else if (r_in_dist <= r_near_limit) begin
                        w_speed  = w_run_speed;
                        n_offset = w_run_offset;
                    end
                end
                MODE_TEMP: begin
                    if (r_hot) begin
                        w_speed  = w_run_speed;
                        n_offset = w_run_offset;
                    end
                end
                default: begin
                    w_speed  = w_run_speed;
                    n_offset = w_run_offset;
                end
            endcase
            n_held = w_speed;
            n_hot  = r_in_temp > r_hot_thr;
        end else if (w_byte_valid) begin
            case (w_cmd)
                CMD_MOTION: n_mode   = MODE_MOTION;
                CMD_TEMP:   n_mode   = MODE_TEMP;
                CMD_MANUAL: n_mode   = MODE_MANUAL;
                CMD_UP:     n_offset = sat_offset(w_off_wide + w_step_wide);
                CMD_DOWN:   n_offset = sat_offset(w_off_wide - w_step_wide);
                CMD_ZERO:   n_offset = '0;
                default:    n_offset = r_offset;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_step <= RST_OFFSET_STEP;
            r_near_limit  <= RST_NEAR_LIMIT_MM;
            r_hot_thr     <= RST_HOT_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET_STEP:   r_offset_step <= i_cfg_data[STEP_W-1:0];
                CFG_NEAR_LIMIT_MM: r_near_limit  <= i_cfg_data[DIST_W-1:0];
                CFG_HOT_THRESHOLD: r_hot_thr     <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_MANUAL;
            r_offset    <= '0;
            r_held      <= '0;
            r_hot       <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_tick) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_held   <= n_held;
            r_hot    <= n_hot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op      <= t_opcode'(i_req.opcode);
            r_in_byte    <= i_req.rx_byte;
            r_in_pot     <= i_req.pot_level;
            r_in_temp    <= i_req.temp_level;
            r_in_dist    <= i_req.distance_mm;
            r_in_dist_ok <= i_req.distance_ok;
            r_in_b1_n    <= i_req.button_one_n;
            r_in_b2_n    <= i_req.button_two_n;
            r_in_b3_n    <= i_req.button_three_n;
        end
        if (w_advance && w_tick) begin
            r_out_speed  <= w_speed;
            r_out_mode   <= n_mode;
            r_out_offset <= n_offset;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.motor_speed  = r_out_speed;
    assign o_rsp.fan_mode     = r_out_mode;
    assign o_rsp.offset_value = r_out_offset;

endmodule

>>> hdl/fmsc_checker.sv
`include "assert_macros.svh"

module fmsc_checker
    import fmsc_pkg::*;
#(
    parameter int OFFSET_LIMIT = 8192,
    parameter int OFFSET_W     = 15
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [SPEED_W-1:0]         i_motor_speed,
    input logic signed [OFFSET_W-1:0] i_offset_value
);

    `ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    `ASSERT_NEXT(a_speed_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_motor_speed), "speed changed while stalled")

    `ASSERT_ALWAYS(a_speed_range, i_clk, i_rst_n, !i_out_valid || i_motor_speed <= SPEED_W'(FULL_SCALE), "speed above full scale")

    `ASSERT_ALWAYS(a_offset_range, i_clk, i_rst_n, !i_out_valid || (i_offset_value <= OFFSET_LIMIT && i_offset_value >= -OFFSET_LIMIT), "offset out of range")

endmodule

bind fan_mode_speed_controller_unit fmsc_checker #(
    .OFFSET_LIMIT (OFFSET_LIMIT),
    .OFFSET_W     (OFFSET_W)
) u_fmsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_motor_speed  (o_rsp.motor_speed),
    .i_offset_value (o_rsp.offset_value)
);
